// ----- rtl/core/wps_pkg.sv -----
`default_nettype none

package wps_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int BITS_LEFT_W = $clog2(BITS_PER_PIXEL);
    localparam int COLOR_W = 8;
    localparam int OP_W = 2;
    localparam int TICK_W = 16;
    localparam int CFG_COUNT = 7;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RST_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RST_HIGH = 3'd6;

    localparam logic [TICK_W-1:0] CFG_RESET [CFG_COUNT] = '{
        16'd7, 16'd1, 16'd2, 16'd5, 16'd10, 16'd1000, 16'd10
    };

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LOAD,
        CMD_RESET,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [BITS_PER_PIXEL-1:0] pixel;
    } cmd_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_BIT_HIGH = 6'b000010,
        PH_BIT_LOW  = 6'b000100,
        PH_LATCH    = 6'b001000,
        PH_RST_LOW  = 6'b010000,
        PH_RST_HIGH = 6'b100000
    } phase_t;

    function automatic logic [TICK_W-1:0] tick_count(input logic [TICK_W-1:0] v);
        tick_count = (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wps_front.sv -----
`default_nettype none

module wps_front (
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  blue,
    input  wire logic        enable,
    output wps_pkg::cmd_t    cmd
);
    import wps_pkg::*;

    logic [3*COLOR_W-1:0] color;

    assign color = enable ? {green, red, blue} : '0;

    always_comb
    begin
        cmd.pixel = BITS_PER_PIXEL'(color) << (BITS_PER_PIXEL - 3*COLOR_W);
        unique case (operation)
            OP_TICK:  cmd.kind = CMD_TICK;
            OP_LOAD:  cmd.kind = CMD_LOAD;
            OP_RESET: cmd.kind = CMD_RESET;
            default:  cmd.kind = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/wps_fifo.sv -----
`default_nettype none

module wps_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire wps_pkg::cmd_t         push_cmd,
    output logic                       full,
    input  wire logic                  pop,
    output wps_pkg::cmd_t              pop_cmd,
    output logic                       not_empty,
    output logic [wps_pkg::QCNT_W-1:0] level
);
    import wps_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign level     = cnt_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wps_back.sv -----
`default_nettype none

module wps_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wps_pkg::TICK_W-1:0]    cfg_data,
    input  wire logic                     cmd_valid,
    input  wire wps_pkg::cmd_t            cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          line_level,
    output logic                          busy_res,
    output logic                          refused,
    output logic                          frame_done
);
    import wps_pkg::*;

    logic [TICK_W-1:0]         cfg_reg [CFG_COUNT];
    logic [BITS_PER_PIXEL-1:0] shift_reg;
    logic [BITS_PER_PIXEL-1:0] shift_next;
    logic [BITS_LEFT_W-1:0]    bits_left_reg;
    logic [BITS_LEFT_W-1:0]    bits_left_next;
    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic [TICK_W-1:0]         count_reg;
    logic [TICK_W-1:0]         count_next;
    logic [TICK_W-1:0]         count_dec;
    logic                      line_reg;
    logic                      line_next;
    logic                      refused_next;
    logic                      done_next;
    logic                      busy;
    logic                      out_valid_reg;
    logic                      line_level_reg;
    logic                      busy_res_reg;
    logic                      refused_reg;
    logic                      frame_done_reg;

    assign busy       = (phase_reg != PH_IDLE);
    assign cmd_pop    = cmd_valid && (!out_valid_reg || out_ready);
    assign count_dec  = (count_reg != '0) ? count_reg - 1'b1 : '0;
    assign out_valid  = out_valid_reg;
    assign line_level = line_level_reg;
    assign busy_res   = busy_res_reg;
    assign refused    = refused_reg;
    assign frame_done = frame_done_reg;

    always_comb
    begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        line_next      = line_reg;
        refused_next   = 1'b0;
        done_next      = 1'b0;
        unique case (cmd.kind)
            CMD_LOAD:
            begin
                if (busy)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    shift_next     = cmd.pixel;
                    bits_left_next = BITS_LEFT_W'(BITS_PER_PIXEL - 1);
                    phase_next     = PH_BIT_HIGH;
                    count_next     = cmd.pixel[BITS_PER_PIXEL-1]
                                   ? tick_count(cfg_reg[REG_ONE_HIGH])
                                   : tick_count(cfg_reg[REG_ZERO_HIGH]);
                    line_next      = 1'b1;
                end
            end
            CMD_RESET:
            begin
                if (busy)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_RST_LOW;
                    count_next = tick_count(cfg_reg[REG_RST_LOW]);
                    line_next  = 1'b0;
                end
            end
            CMD_TICK:
            begin
                if (busy)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        unique case (phase_reg)
                            PH_BIT_HIGH:
                            begin
                                phase_next = PH_BIT_LOW;
                                count_next = shift_reg[BITS_PER_PIXEL-1]
                                           ? tick_count(cfg_reg[REG_ONE_LOW])
                                           : tick_count(cfg_reg[REG_ZERO_LOW]);
                                line_next  = 1'b0;
                            end
                            PH_BIT_LOW:
                            begin
                                if (bits_left_reg == '0)
                                begin
                                    phase_next = PH_LATCH;
                                    count_next = tick_count(cfg_reg[REG_LATCH]);
                                    line_next  = 1'b0;
                                end
                                else
                                begin
                                    bits_left_next = bits_left_reg - 1'b1;
                                    shift_next     = {shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
                                    phase_next     = PH_BIT_HIGH;
                                    count_next     = shift_reg[BITS_PER_PIXEL-2]
                                                   ? tick_count(cfg_reg[REG_ONE_HIGH])
                                                   : tick_count(cfg_reg[REG_ZERO_HIGH]);
                                    line_next      = 1'b1;
                                end
                            end
                            PH_LATCH:
                            begin
                                phase_next = PH_IDLE;
                                line_next  = 1'b0;
                                done_next  = 1'b1;
                            end
                            PH_RST_LOW:
                            begin
                                phase_next = PH_RST_HIGH;
                                count_next = tick_count(cfg_reg[REG_RST_HIGH]);
                                line_next  = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                line_next  = 1'b1;
                                done_next  = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_write && (cfg_index < CFG_IDX_W'(CFG_COUNT)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bits_left_reg <= '0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            line_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                shift_reg     <= shift_next;
                bits_left_reg <= bits_left_next;
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                line_reg      <= line_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            line_level_reg <= line_next;
            busy_res_reg   <= (phase_next != PH_IDLE);
            refused_reg    <= refused_next;
            frame_done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ws2812_pixel_serializer.sv -----
// channel | signals                                   | accepted when
// --------+-------------------------------------------+----------------------
// in      | in_valid in_ready operation green red     | in_valid & in_ready
//         | blue enable                               |
// out     | out_valid out_ready line_level busy_res   | out_valid & out_ready
//         | refused frame_done                        |
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | cfg_valid & cfg_ready
//
// one item per cycle sustained while out_ready stays high; each item passes
// through the two-entry command queue and then the output register
// the waveform engine retires one queued command per cycle unless the output stalls
// in_ready drops only when the queue is full, which needs out_ready low
// cfg_ready is always high; no clearing pass after reset
`default_nettype none

module ws2812_pixel_serializer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  blue,
    input  wire logic        enable,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             line_level,
    output logic             busy_res,
    output logic             refused,
    output logic             frame_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wps_pkg::TICK_W-1:0]    cfg_data
);
    import wps_pkg::*;

    cmd_t              front_cmd;
    cmd_t              queue_cmd;
    logic              queue_full;
    logic              queue_not_empty;
    logic              queue_pop;
    logic [QCNT_W-1:0] queue_level;

    assign in_ready  = !queue_full;
    assign cfg_ready = 1'b1;

    wps_front u_front (
        .operation (operation),
        .green     (green),
        .red       (red),
        .blue      (blue),
        .enable    (enable),
        .cmd       (front_cmd)
    );

    wps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_cmd   (queue_cmd),
        .not_empty (queue_not_empty),
        .level     (queue_level)
    );

    wps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (queue_not_empty),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_level (line_level),
        .busy_res   (busy_res),
        .refused    (refused),
        .frame_done (frame_done)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !busy_res)
        else $error("frame_done reported while still busy");

    a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && refused |-> busy_res)
        else $error("refused item reported while idle");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        queue_level <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue overflow");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import wps_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic lvl;
        logic busy;
        logic refusal;
        logic done;
    } line_state_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      operation;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   blue;
    logic                 enable;
    logic                 out_valid;
    logic                 out_ready;
    logic                 line_level;
    logic                 busy_res;
    logic                 refused;
    logic                 frame_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    // waveform predictor state
    logic [TICK_W-1:0]         cfg_ticks [CFG_COUNT];
    logic [BITS_PER_PIXEL-1:0] pixel_bits;
    logic [BITS_LEFT_W-1:0]    bits_to_go;
    phase_t                    wave_phase;
    logic [TICK_W-1:0]         phase_ticks;
    logic                      line_q;

    line_state_t expected_waveform [$];
    int          fault_count;
    int          in_idle_pct;
    int          out_stall_pct;
    int          hold_requests;
    int          hold_seen;
    int          hold_left;

    ws2812_pixel_serializer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .green      (green),
        .red        (red),
        .blue       (blue),
        .enable     (enable),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_level (line_level),
        .busy_res   (busy_res),
        .refused    (refused),
        .frame_done (frame_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("ws2812_pixel_serializer: mismatch");
        $finish;
    end

    function automatic logic [TICK_W-1:0] reg_ticks(input logic [CFG_IDX_W-1:0] idx);
        reg_ticks = (cfg_ticks[idx] == '0) ? TICK_W'(1) : cfg_ticks[idx];
    endfunction

    function automatic void reset_model();
        cfg_ticks[REG_ONE_HIGH]  = 16'd7;
        cfg_ticks[REG_ONE_LOW]   = 16'd1;
        cfg_ticks[REG_ZERO_HIGH] = 16'd2;
        cfg_ticks[REG_ZERO_LOW]  = 16'd5;
        cfg_ticks[REG_LATCH]     = 16'd10;
        cfg_ticks[REG_RST_LOW]   = 16'd1000;
        cfg_ticks[REG_RST_HIGH]  = 16'd10;
        pixel_bits  = '0;
        bits_to_go  = '0;
        wave_phase  = PH_IDLE;
        phase_ticks = '0;
        line_q      = 1'b0;
    endfunction

    function automatic void begin_bit();
        wave_phase  = PH_BIT_HIGH;
        phase_ticks = pixel_bits[BITS_PER_PIXEL-1] ? reg_ticks(REG_ONE_HIGH)
                                                   : reg_ticks(REG_ZERO_HIGH);
        line_q      = 1'b1;
    endfunction

    task automatic predict_waveform(input logic [OP_W-1:0] op, input logic [7:0] g,
                                    input logic [7:0] r, input logic [7:0] b,
                                    input logic en, output line_state_t res);
        logic was_busy;
        logic refd;
        logic done;
        was_busy = (wave_phase != PH_IDLE);
        refd     = 1'b0;
        done     = 1'b0;
        if (op == OP_LOAD || op == OP_RESET)
        begin
            if (was_busy)
            begin
                refd = 1'b1;
            end
            else if (op == OP_LOAD)
            begin
                pixel_bits = '0;
                if (en)
                begin
                    pixel_bits[BITS_PER_PIXEL-1 -: 24] = {g, r, b};
                end
                bits_to_go = BITS_LEFT_W'(BITS_PER_PIXEL - 1);
                begin_bit();
            end
            else
            begin
                wave_phase  = PH_RST_LOW;
                phase_ticks = reg_ticks(REG_RST_LOW);
                line_q      = 1'b0;
            end
        end
        else if (op == OP_TICK && was_busy)
        begin
            if (phase_ticks != '0)
            begin
                phase_ticks = phase_ticks - 1'b1;
            end
            if (phase_ticks == '0)
            begin
                case (wave_phase)
                    PH_BIT_HIGH:
                    begin
                        wave_phase  = PH_BIT_LOW;
                        phase_ticks = pixel_bits[BITS_PER_PIXEL-1] ? reg_ticks(REG_ONE_LOW)
                                                                   : reg_ticks(REG_ZERO_LOW);
                        line_q      = 1'b0;
                    end
                    PH_BIT_LOW:
                    begin
                        if (bits_to_go == '0)
                        begin
                            wave_phase  = PH_LATCH;
                            phase_ticks = reg_ticks(REG_LATCH);
                            line_q      = 1'b0;
                        end
                        else
                        begin
                            bits_to_go = bits_to_go - 1'b1;
                            pixel_bits = pixel_bits << 1;
                            begin_bit();
                        end
                    end
                    PH_LATCH:
                    begin
                        wave_phase = PH_IDLE;
                        line_q     = 1'b0;
                        done       = 1'b1;
                    end
                    PH_RST_LOW:
                    begin
                        wave_phase  = PH_RST_HIGH;
                        phase_ticks = reg_ticks(REG_RST_HIGH);
                        line_q      = 1'b1;
                    end
                    default:
                    begin
                        wave_phase = PH_IDLE;
                        line_q     = 1'b1;
                        done       = 1'b1;
                    end
                endcase
            end
        end
        res.lvl     = line_q;
        res.busy    = (wave_phase != PH_IDLE);
        res.refusal = refd;
        res.done    = done;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] g,
                             input logic [7:0] r, input logic [7:0] b, input logic en);
        line_state_t res;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        green     <= g;
        red       <= r;
        blue      <= b;
        enable    <= en;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_waveform(op, g, r, b, en, res);
        expected_waveform.push_back(res);
    endtask

    task automatic tick_until_idle();
        while (wave_phase != PH_IDLE)
        begin
            send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_waveform.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_ticks[idx] = v;
    endtask

    task automatic program_regs(input logic [15:0] oh, input logic [15:0] ol,
                                input logic [15:0] zh, input logic [15:0] zl,
                                input logic [15:0] lt, input logic [15:0] rl,
                                input logic [15:0] rh);
        tick_until_idle();
        wait_results_done();
        repeat (3) @(posedge clk);
        write_reg(REG_ONE_HIGH, oh);
        write_reg(REG_ONE_LOW, ol);
        write_reg(REG_ZERO_HIGH, zh);
        write_reg(REG_ZERO_LOW, zl);
        write_reg(REG_LATCH, lt);
        write_reg(REG_RST_LOW, rl);
        write_reg(REG_RST_HIGH, rh);
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
            fault_count++;
        end
    endfunction

    task automatic check_result();
        line_state_t want;
        if (expected_waveform.size() == 0)
        begin
            $display("%0t: unexpected item, expected none actual %0b%0b%0b%0b", $time,
                     line_level, busy_res, refused, frame_done);
            fault_count++;
        end
        else
        begin
            want = expected_waveform.pop_front();
            check_field("line_level", want.lvl, line_level);
            check_field("busy_res", want.busy, busy_res);
            check_field("refused", want.refusal, refused);
            check_field("frame_done", want.done, frame_done);
        end
    endtask

    // output side: random stalls plus requested long hold-offs
    initial
    begin
        out_ready <= 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    task automatic test_reset_values();
        send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(OP_IGNORED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        repeat (3) send_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // refused while a frame runs
        send_item(OP_LOAD, 8'h12, 8'h34, 8'h56, 1'b1);
        send_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(OP_IGNORED, 8'h00, 8'h00, 8'h00, 1'b0);
        tick_until_idle();
        send_item(OP_RESET, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        repeat (5) send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(OP_LOAD, 8'hAA, 8'hAA, 8'hAA, 1'b1);
        tick_until_idle();
        // line stays high after the reset pulse
        send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(OP_IGNORED, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(OP_LOAD, 8'hAA, 8'h55, 8'hA5, 1'b1);
        tick_until_idle();
    endtask

    task automatic test_short_timing();
        program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(OP_LOAD, 8'h55, 8'hAA, 8'h5A, 1'b1);
        tick_until_idle();
        send_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0);
        tick_until_idle();
        // enable clear sends zeros
        send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        tick_until_idle();
        send_item(OP_LOAD, 8'h80, 8'h01, 8'hFE, 1'b1);
        tick_until_idle();
        // a zero count behaves as one tick
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(OP_LOAD, 8'h0F, 8'hF0, 8'h3C, 1'b1);
        tick_until_idle();
        send_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0);
        tick_until_idle();
    endtask

    task automatic test_long_timing();
        program_regs(16'h0102, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(OP_LOAD, 8'h80, 8'h00, 8'h00, 1'b1);
        tick_until_idle();
        send_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0);
        tick_until_idle();
    endtask

    task automatic test_backpressure();
        int k;
        program_regs(16'd3, 16'd2, 16'd1, 16'd3, 16'd4, 16'd5, 16'd2);
        hold_requests++;
        send_item(OP_LOAD, 8'hC3, 8'h3C, 8'h99, 1'b1);
        for (k = 0; k < 60; k++)
        begin
            send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(), 1'b1);
        end
        wait_results_done();
        tick_until_idle();
    endtask

    task automatic run_random_phase(input int in_pct, input int out_pct, input int n_items);
        int setting;
        int counted;
        int pick;
        logic [OP_W-1:0] op;
        logic was_busy;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        for (setting = 0; setting < 2; setting++)
        begin
            program_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                         16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                         16'($urandom_range(0, 12)), 16'($urandom_range(1, 30)),
                         16'($urandom_range(0, 8)));
            counted = 0;
            while (counted < n_items / 2)
            begin
                was_busy = (wave_phase != PH_IDLE);
                pick = $urandom_range(99);
                if (!was_busy)
                begin
                    op = (pick < 62) ? OP_LOAD : (pick < 78) ? OP_RESET :
                         (pick < 92) ? OP_TICK : OP_IGNORED;
                end
                else
                begin
                    op = (pick < 88) ? OP_TICK : (pick < 93) ? OP_LOAD :
                         (pick < 97) ? OP_RESET : OP_IGNORED;
                end
                send_item(op, rand_byte(), rand_byte(), rand_byte(), $urandom_range(99) < 85);
                if (op != OP_IGNORED && (op != OP_TICK || was_busy))
                begin
                    counted++;
                end
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(0, 0, 100);
        run_random_phase(74, 0, 100);
        run_random_phase(0, 74, 100);
        run_random_phase(36, 36, 100);
    endtask

    initial
    begin
        fault_count   = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_requests = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_TICK;
        green     <= '0;
        red       <= '0;
        blue      <= '0;
        enable    <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ONE_HIGH;
        cfg_data  <= '0;
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_short_timing();
        test_long_timing();
        test_backpressure();
        test_random();

        tick_until_idle();
        wait_results_done();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("ws2812_pixel_serializer: match");
        end
        else
        begin
            $display("ws2812_pixel_serializer: mismatch");
        end
        $finish;
    end

endmodule
